// File: src/bve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bve_pkg: shared types and constants of the body velocity estimator
// Register indexes, reset values, field widths and the queue entry type.
// ----------------------------------------------------------------------------
package bve_pkg;

   localparam int AXES_DEFAULT        = 3;
   localparam int VALUE_WIDTH_DEFAULT = 24;
   localparam int POS_WIDTH           = 24;
   localparam int QUAT_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SETTLE_TICKS   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SAMPLE_RATE    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_LAST_VEL  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_PRIOR_VEL = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_POSITION  = 3'd4;

   localparam logic [15:0]        SETTLE_TICKS_RESET   = 16'd67;
   localparam logic [23:0]        SAMPLE_RATE_RESET    = 24'd4369067;
   localparam logic signed [17:0] COEF_LAST_VEL_RESET  = 18'sd21666;
   localparam logic signed [17:0] COEF_PRIOR_VEL_RESET = -18'sd1790;
   localparam logic signed [23:0] COEF_POSITION_RESET  = 24'sd2339635;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0]  pos_x;
      logic signed [POS_WIDTH-1:0]  pos_y;
      logic signed [POS_WIDTH-1:0]  pos_z;
      logic signed [QUAT_WIDTH-1:0] quat_w;
      logic signed [QUAT_WIDTH-1:0] quat_x;
      logic signed [QUAT_WIDTH-1:0] quat_y;
      logic signed [QUAT_WIDTH-1:0] quat_z;
      logic                         filt;
   } job_type;

endpackage

// File: src/bve_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bve_if: handshake channels of the body velocity estimator
// Request, response and register write channels with source and sink views.
// ----------------------------------------------------------------------------
interface bve_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [bve_pkg::POS_WIDTH-1:0]  pos_x;
   logic signed [bve_pkg::POS_WIDTH-1:0]  pos_y;
   logic signed [bve_pkg::POS_WIDTH-1:0]  pos_z;
   logic signed [bve_pkg::QUAT_WIDTH-1:0] quat_w;
   logic signed [bve_pkg::QUAT_WIDTH-1:0] quat_x;
   logic signed [bve_pkg::QUAT_WIDTH-1:0] quat_y;
   logic signed [bve_pkg::QUAT_WIDTH-1:0] quat_z;
   modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                 output ready);
endinterface

interface bve_rsp_if #(parameter int VALUE_WIDTH = bve_pkg::VALUE_WIDTH_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] earth_vx;
   logic signed [VALUE_WIDTH-1:0] earth_vy;
   logic signed [VALUE_WIDTH-1:0] earth_vz;
   logic signed [VALUE_WIDTH-1:0] body_vx;
   logic signed [VALUE_WIDTH-1:0] body_vy;
   logic signed [VALUE_WIDTH-1:0] body_vz;
   modport source (output valid, earth_vx, earth_vy, earth_vz, body_vx, body_vy, body_vz,
                   input ready);
   modport sink (input valid, earth_vx, earth_vy, earth_vz, body_vx, body_vy, body_vz,
                 output ready);
endinterface

interface bve_csr_if;
   logic                                       valid;
   logic                                       ready;
   logic [bve_pkg::CSR_INDEX_WIDTH-1:0]        index;
   logic [bve_pkg::CSR_DATA_WIDTH-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/bve_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bve_front: request intake and mode selection
// Counts ticks, decides raw or filtered differencing and queues each item.
// ----------------------------------------------------------------------------
module bve_front (
   input  logic             clock,
   input  logic             reset,
   bve_req_if.sink          req,
   input  logic [15:0]      settle_ticks,
   output logic             job_valid,
   input  logic             job_ready,
   output bve_pkg::job_type job
);

   localparam int DEPTH = 2;

   bve_pkg::job_type queue_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic [15:0]      tick_ff, tick_in;
   logic             push, pop;
   bve_pkg::job_type entry;

   assign req.ready = (count_ff != 2'(DEPTH));
   assign push      = req.valid && req.ready;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      entry.pos_x  = req.pos_x;
      entry.pos_y  = req.pos_y;
      entry.pos_z  = req.pos_z;
      entry.quat_w = req.quat_w;
      entry.quat_x = req.quat_x;
      entry.quat_y = req.quat_y;
      entry.quat_z = req.quat_z;
      entry.filt   = (tick_ff >= settle_ticks);
      wr_ptr_in    = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + 2'(push) - 2'(pop);
      tick_in      = (push && tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         tick_ff   <= 16'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         tick_ff   <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// File: src/bve_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bve_back: velocity arithmetic on one shared multiplier
// Sequences differencing, filtering, matrix build and rotation per item.
// ----------------------------------------------------------------------------
module bve_back #(
   parameter int AXES        = bve_pkg::AXES_DEFAULT,
   parameter int VALUE_WIDTH = bve_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  bve_pkg::job_type        job,
   input  logic [23:0]             sample_rate,
   input  logic signed [17:0]      coef_last_vel,
   input  logic signed [17:0]      coef_prior_vel,
   input  logic signed [23:0]      coef_position,
   bve_rsp_if.source               rsp
);

   localparam int VW = VALUE_WIDTH;
   localparam int PW = bve_pkg::POS_WIDTH;
   localparam int AW = 64;
   localparam logic signed [AW-1:0] HALF16 = AW'(64'sd32768);
   localparam logic signed [AW-1:0] HALF12 = AW'(64'sd2048);
   localparam logic signed [AW-1:0] ONE28  = AW'(64'sd268435456);
   localparam logic signed [AW-1:0] VMAX   = AW'((64'sd1 <<< (VW - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] VMIN   = -VMAX - AW'(64'sd1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_VEL   = 5'b00010,
      ST_MAT   = 5'b00100,
      ST_ROT   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   bve_pkg::job_type        job_ff;
   logic [1:0]              axis_ff, axis_in;
   logic [1:0]              term_ff, term_in;
   logic [3:0]              ent_ff, ent_in;
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic signed [PW-1:0]    prev_pos_ff [3];
   logic signed [VW-1:0]    last_vel_ff [3];
   logic signed [VW-1:0]    prior_vel_ff [3];
   logic signed [VW-1:0]    ve_ff [3];
   logic signed [VW-1:0]    vb_ff [3];
   logic signed [AW-1:0]    mat_ff [9];
   logic signed [31:0]      op_a, op_b;
   logic signed [AW-1:0]    prod_ff;
   logic                    prod_vld_ff;
   logic signed [PW:0]      diff;
   logic signed [PW:0]      pos_sel;
   logic signed [15:0]      qw, qx, qy, qz;
   logic signed [AW-1:0]    rnd16, satv;
   logic                    load, acc_done;
   // in the cycle after the final add the accumulator is complete and is written back
   logic                    acc_done_d;
   logic                    issue;

   assign qw = job_ff.quat_w;
   assign qx = job_ff.quat_x;
   assign qy = job_ff.quat_y;
   assign qz = job_ff.quat_z;

   always_comb begin
      case (axis_ff)
         2'd0:    pos_sel = (PW+1)'(job_ff.pos_x);
         2'd1:    pos_sel = (PW+1)'(job_ff.pos_y);
         default: pos_sel = (PW+1)'(job_ff.pos_z);
      endcase
   end

   assign diff = pos_sel - (PW+1)'(prev_pos_ff[axis_ff]);

   // operand selection for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_VEL: begin
            if (!job_ff.filt) begin
               op_a = 32'(diff);
               op_b = 32'(signed'({1'b0, sample_rate}));
            end else begin
               case (term_ff)
                  2'd0:    begin op_a = 32'(last_vel_ff[axis_ff]);
                                 op_b = 32'(coef_last_vel); end
                  2'd1:    begin op_a = 32'(prior_vel_ff[axis_ff]);
                                 op_b = 32'(coef_prior_vel); end
                  default: begin op_a = 32'(diff);
                                 op_b = 32'(coef_position); end
               endcase
            end
         end
         ST_MAT: begin
            // two products per entry: term 0 and term 1
            case (ent_ff)
               4'd0, 4'd4, 4'd8: begin
                  op_a = 32'(qw); op_b = 32'(qw);
                  if (term_ff != 2'd0) begin
                     case (ent_ff)
                        4'd0:    begin op_a = 32'(qx); op_b = 32'(qx); end
                        4'd4:    begin op_a = 32'(qy); op_b = 32'(qy); end
                        default: begin op_a = 32'(qz); op_b = 32'(qz); end
                     endcase
                  end
               end
               4'd1, 4'd3: begin
                  op_a = (term_ff == 2'd0) ? 32'(qx) : 32'(qw);
                  op_b = (term_ff == 2'd0) ? 32'(qy) : 32'(qz);
               end
               4'd2, 4'd6: begin
                  op_a = (term_ff == 2'd0) ? 32'(qx) : 32'(qw);
                  op_b = (term_ff == 2'd0) ? 32'(qz) : 32'(qy);
               end
               default: begin
                  op_a = (term_ff == 2'd0) ? 32'(qy) : 32'(qw);
                  op_b = (term_ff == 2'd0) ? 32'(qz) : 32'(qx);
               end
            endcase
         end
         ST_ROT: begin
            op_a = 32'(mat_ff[{2'b00, axis_ff} * 4'd3 + {2'b00, term_ff}]);
            op_b = 32'(ve_ff[term_ff]);
         end
         default: ;
      endcase
   end

   function automatic logic signed [AW-1:0] sat_fn(input logic signed [AW-1:0] x);
      logic signed [AW-1:0] r;
      r = x;
      if (x > VMAX) r = VMAX;
      if (x < VMIN) r = VMIN;
      return r;
   endfunction

   assign rnd16 = (acc_ff + HALF16) >>> 16;
   assign satv  = sat_fn(rnd16);

   assign load      = (state_ff == ST_IDLE) && job_valid;
   assign job_ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);

   // subtract flag for matrix entries whose second product is negated
   logic mat_neg;
   always_comb begin
      case (ent_ff)
         4'd2, 4'd3, 4'd7: mat_neg = 1'b1;
         default:          mat_neg = 1'b0;
      endcase
   end

   // a step issues a product in phase 0 and accumulates it in phase 1
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      term_in  = term_ff;
      ent_in   = ent_ff;
      acc_in   = acc_ff;
      acc_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_VEL;
               axis_in  = 2'd0;
               term_in  = 2'd0;
               acc_in   = '0;
            end
         end
         ST_VEL: begin
            if (prod_vld_ff) begin
               acc_in = acc_ff + prod_ff;
               if (!job_ff.filt || term_ff == 2'd2) begin
                  acc_done = 1'b1;
                  term_in  = 2'd0;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end
            if (acc_done_d) begin
               acc_in = '0;
               if (axis_ff == 2'd2) begin
                  state_in = ST_MAT;
                  ent_in   = 4'd0;
                  axis_in  = 2'd0;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_MAT: begin
            if (prod_vld_ff) begin
               acc_in = (mat_neg && term_ff == 2'd1) ? acc_ff - prod_ff : acc_ff + prod_ff;
               if (term_ff == 2'd1) begin
                  acc_done = 1'b1;
                  term_in  = 2'd0;
               end else begin
                  term_in = 2'd1;
               end
            end
            if (acc_done_d) begin
               acc_in = '0;
               if (ent_ff == 4'd8) begin
                  state_in = ST_ROT;
                  axis_in  = 2'd0;
               end else begin
                  ent_in = ent_ff + 4'd1;
               end
            end
         end
         ST_ROT: begin
            if (prod_vld_ff) begin
               acc_in = acc_ff + prod_ff;
               if (term_ff == 2'd2) begin
                  acc_done = 1'b1;
                  term_in  = 2'd0;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end
            if (acc_done_d) begin
               acc_in = '0;
               if (axis_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign issue = !prod_vld_ff && !acc_done_d &&
                  (state_ff == ST_VEL || state_ff == ST_MAT || state_ff == ST_ROT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         prod_vld_ff <= 1'b0;
         acc_done_d  <= 1'b0;
         axis_ff     <= 2'd0;
         term_ff     <= 2'd0;
         ent_ff      <= 4'd0;
         for (int i = 0; i < 3; i++) begin
            prev_pos_ff[i]  <= '0;
            last_vel_ff[i]  <= '0;
            prior_vel_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         prod_vld_ff <= issue;
         acc_done_d  <= acc_done;
         axis_ff     <= axis_in;
         term_ff     <= term_in;
         ent_ff      <= ent_in;
         if (state_ff == ST_VEL && acc_done_d) begin
            if (32'(axis_ff) < AXES) begin
               prior_vel_ff[axis_ff] <= last_vel_ff[axis_ff];
               last_vel_ff[axis_ff]  <= VW'(satv);
               prev_pos_ff[axis_ff]  <= pos_sel[PW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= AW'(op_a * op_b);
      if (load) begin
         job_ff <= job;
      end
      if (state_ff == ST_VEL && acc_done_d) begin
         ve_ff[axis_ff] <= (32'(axis_ff) < AXES) ? VW'(satv) : '0;
      end
      if (state_ff == ST_MAT && acc_done_d) begin
         if (ent_ff inside {4'd0, 4'd4, 4'd8}) begin
            mat_ff[ent_ff] <= AW'((((acc_ff <<< 1) - ONE28) + HALF12) >>> 12);
         end else begin
            mat_ff[ent_ff] <= AW'(((acc_ff <<< 1) + HALF12) >>> 12);
         end
      end
      if (state_ff == ST_ROT && acc_done_d) begin
         vb_ff[axis_ff] <= VW'(satv);
      end
   end

   assign rsp.earth_vx = ve_ff[0];
   assign rsp.earth_vy = ve_ff[1];
   assign rsp.earth_vz = ve_ff[2];
   assign rsp.body_vx  = vb_ff[0];
   assign rsp.body_vy  = vb_ff[1];
   assign rsp.body_vz  = vb_ff[2];

endmodule

// File: src/bve_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bve_csr: configuration registers
// Holds the warm-up length, sample rate and filter weights.
// ----------------------------------------------------------------------------
module bve_csr (
   input  logic               clock,
   input  logic               reset,
   bve_csr_if.sink            csr,
   output logic [15:0]        settle_ticks,
   output logic [23:0]        sample_rate,
   output logic signed [17:0] coef_last_vel,
   output logic signed [17:0] coef_prior_vel,
   output logic signed [23:0] coef_position
);

   logic [15:0]        settle_ff;
   logic [23:0]        rate_ff;
   logic signed [17:0] clast_ff;
   logic signed [17:0] cprior_ff;
   logic signed [23:0] cpos_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= bve_pkg::SETTLE_TICKS_RESET;
         rate_ff   <= bve_pkg::SAMPLE_RATE_RESET;
         clast_ff  <= bve_pkg::COEF_LAST_VEL_RESET;
         cprior_ff <= bve_pkg::COEF_PRIOR_VEL_RESET;
         cpos_ff   <= bve_pkg::COEF_POSITION_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            bve_pkg::REG_SETTLE_TICKS:   settle_ff <= csr.data[15:0];
            bve_pkg::REG_SAMPLE_RATE:    rate_ff   <= csr.data;
            bve_pkg::REG_COEF_LAST_VEL:  clast_ff  <= csr.data[17:0];
            bve_pkg::REG_COEF_PRIOR_VEL: cprior_ff <= csr.data[17:0];
            bve_pkg::REG_COEF_POSITION:  cpos_ff   <= csr.data;
            default: ;
         endcase
      end
   end

   assign settle_ticks   = settle_ff;
   assign sample_rate    = rate_ff;
   assign coef_last_vel  = clast_ff;
   assign coef_prior_vel = cprior_ff;
   assign coef_position  = cpos_ff;

endmodule

// File: src/body_velocity_estimator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_velocity_estimator_core: earth and body velocity from sampled position
// Each product is issued to the single shared multiplier and then accumulated,
// and each finished sum is written back after its final add. The back end
// takes a new item only once the result of the last one has been taken; a
// two-entry queue decouples intake.
// Synchronous reset restores register defaults and clears all filter history.
// ----------------------------------------------------------------------------
module body_velocity_estimator_core #(
   parameter int AXES        = bve_pkg::AXES_DEFAULT,
   parameter int VALUE_WIDTH = bve_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bve_req_if.sink   req,
   bve_rsp_if.source rsp,
   bve_csr_if.sink   csr
);

   logic [15:0]        settle_ticks;
   logic [23:0]        sample_rate;
   logic signed [17:0] coef_last_vel;
   logic signed [17:0] coef_prior_vel;
   logic signed [23:0] coef_position;
   logic               job_valid, job_ready;
   bve_pkg::job_type   job;

   bve_csr u_csr (
      .clock, .reset, .csr,
      .settle_ticks, .sample_rate, .coef_last_vel, .coef_prior_vel, .coef_position
   );

   bve_front u_front (
      .clock, .reset, .req, .settle_ticks, .job_valid, .job_ready, .job
   );

   bve_back #(.AXES(AXES), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .sample_rate, .coef_last_vel, .coef_prior_vel, .coef_position, .rsp
   );

endmodule
